// ----- hw/rtl/d2fa_pkg.sv -----
`timescale 1ns / 1ps

package d2fa_pkg;

    localparam int MAX_PRECISION  = 9;
    localparam int MAX_TEXT_CHARS = 32;
    localparam int MAG_W          = 96;   // scaled magnitude stays below 2^93
    localparam int NUM_DIGITS     = 29;   // decimal digits of a 96-bit value
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2d;
    localparam logic [7:0] CHAR_POINT = 8'h2e;

    localparam logic [0:0] CFG_PRECISION  = 1'b0;
    localparam logic [0:0] CFG_BUFFER_LEN = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_SPACE  = 2'd1,
        ST_BUF_SMALL = 2'd2,
        ST_RANGE     = 2'd3
    } status_t;

    // work descriptor handed from the classifier to the converter
    typedef struct packed {
        logic          stat_only;
        status_t       code;
        logic          neg;
        logic [52:0]   mant;
        logic          shl;
        logic          zero;
        logic [6:0]    sh_amt;
        logic [3:0]    prec;
    } desc_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_MUL,
        B_SHIFT,
        B_ROUND,
        B_CONV,
        B_SCAN,
        B_CHECK,
        B_SIGN,
        B_INT,
        B_DOT,
        B_FRAC,
        B_STAT
    } back_state_t;

endpackage

// ----- hw/rtl/d2fa_front.sv -----
`timescale 1ns / 1ps

module d2fa_front (
    input  logic [63:0]          value_bits,
    input  logic [3:0]           precision,
    input  logic [7:0]           buffer_length,
    output d2fa_pkg::desc_t      desc
);
    import d2fa_pkg::*;

    logic [10:0] expo;
    logic [52:0] mant;
    logic [10:0] rshift;

    assign expo   = value_bits[62:52];
    assign mant   = {(expo != 11'd0), value_bits[51:0]};
    // right shift for negative exponents; subnormals use the minimum exponent
    assign rshift = (expo != 11'd0) ? (11'd1075 - expo) : 11'd1074;

    always_comb
    begin
        desc           = '0;
        desc.mant      = mant;
        desc.neg       = value_bits[63] && (mant != 53'd0);
        desc.prec      = (precision > 4'(MAX_PRECISION)) ? 4'(MAX_PRECISION) : precision;
        desc.shl       = (expo >= 11'd1075);
        desc.zero      = 1'b0;
        desc.sh_amt    = 7'd0;
        desc.code      = ST_OK;
        desc.stat_only = 1'b0;
        if (desc.shl)
        begin
            desc.sh_amt = 7'(expo - 11'd1075);
        end
        else if (rshift > 11'(MAG_W))
        begin
            desc.zero = 1'b1;
        end
        else
        begin
            desc.sh_amt = rshift[6:0];
        end
        if (buffer_length < 8'd2)
        begin
            desc.stat_only = 1'b1;
            desc.code      = ST_BUF_SMALL;
        end
        else if (expo >= 11'd1086)
        begin
            desc.stat_only = 1'b1;
            desc.code      = ST_RANGE;
        end
    end

endmodule

// ----- hw/rtl/d2fa_queue.sv -----
`timescale 1ns / 1ps

module d2fa_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  d2fa_pkg::desc_t      push_data,
    output logic                 full,
    input  logic                 pop,
    output logic                 not_empty,
    output d2fa_pkg::desc_t      head
);
    import d2fa_pkg::*;

    desc_t      entry_reg [QUEUE_DEPTH];
    logic [0:0] wr_ptr_reg, wr_ptr_next;
    logic [0:0] rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full      = (count_reg == 2'(QUEUE_DEPTH));
    assign not_empty = (count_reg != 2'd0);
    assign head      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- hw/rtl/d2fa_back.sv -----
`timescale 1ns / 1ps

module d2fa_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  d2fa_pkg::desc_t      desc,
    output logic                 q_pop,
    input  logic [7:0]           buffer_length,
    output logic [7:0]           out_char,
    output logic                 last,
    output logic [1:0]           status,
    output logic                 out_valid,
    input  logic                 out_ready
);
    import d2fa_pkg::*;

    back_state_t state_reg, state_next;

    logic [MAG_W-1:0] mag_reg, mag_next;
    logic [3:0]       bcd_reg [NUM_DIGITS];
    logic [3:0]       bcd_next [NUM_DIGITS];
    logic [3:0]       adj [NUM_DIGITS];
    logic [3:0]       mul_cnt_reg, mul_cnt_next;
    logic [6:0]       bit_cnt_reg, bit_cnt_next;
    logic [4:0]       pos_reg, pos_next;
    logic             neg_reg, neg_next;
    logic [3:0]       prec_reg, prec_next;
    logic             shl_reg, shl_next;
    logic             zero_reg, zero_next;
    logic [6:0]       amt_reg, amt_next;
    status_t          code_reg, code_next;

    logic [7:0]       char_reg, char_next;
    logic             last_reg, last_next;
    status_t          stat_reg, stat_next;
    logic             valid_reg, valid_next;

    logic             ob_free;
    logic [3:0]       dig;
    logic [5:0]       text_len;
    logic [7:0]       room;
    logic [7:0]       limit;
    logic             too_long;

    assign ob_free  = !valid_reg || out_ready;
    assign dig      = bcd_reg[pos_reg];
    assign text_len = 6'(neg_reg) + 6'(pos_reg) + 6'd1 + 6'(prec_reg != 4'd0);
    assign room     = buffer_length - 8'd1;
    assign limit    = (room > 8'(MAX_TEXT_CHARS)) ? 8'(MAX_TEXT_CHARS) : room;
    assign too_long = ({2'b00, text_len} > limit);

    assign out_char  = char_reg;
    assign last      = last_reg;
    assign status    = stat_reg;
    assign out_valid = valid_reg;

    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            adj[i] = (bcd_reg[i] >= 4'd5) ? bcd_reg[i] + 4'd3 : bcd_reg[i];
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
                if (q_valid)
                begin
                    state_next = desc.stat_only ? B_STAT : B_MUL;
                end
            B_MUL:
                if (mul_cnt_reg == 4'd0)
                begin
                    state_next = B_SHIFT;
                end
            B_SHIFT:
                state_next = (!shl_reg && !zero_reg) ? B_ROUND : B_CONV;
            B_ROUND:
                state_next = B_CONV;
            B_CONV:
                if (bit_cnt_reg == 7'd0)
                begin
                    state_next = B_SCAN;
                end
            B_SCAN:
                if (!(pos_reg > {1'b0, prec_reg} && dig == 4'd0))
                begin
                    state_next = B_CHECK;
                end
            B_CHECK:
                state_next = too_long ? B_STAT : (neg_reg ? B_SIGN : B_INT);
            B_SIGN:
                if (ob_free)
                begin
                    state_next = B_INT;
                end
            B_INT:
                if (ob_free && pos_reg == {1'b0, prec_reg})
                begin
                    state_next = (prec_reg != 4'd0) ? B_DOT : B_IDLE;
                end
            B_DOT:
                if (ob_free)
                begin
                    state_next = B_FRAC;
                end
            B_FRAC:
                if (ob_free && pos_reg == 5'd0)
                begin
                    state_next = B_IDLE;
                end
            B_STAT:
                if (ob_free)
                begin
                    state_next = B_IDLE;
                end
            default:
                state_next = B_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        mag_next     = mag_reg;
        bcd_next     = bcd_reg;
        mul_cnt_next = mul_cnt_reg;
        bit_cnt_next = bit_cnt_reg;
        pos_next     = pos_reg;
        neg_next     = neg_reg;
        prec_next    = prec_reg;
        shl_next     = shl_reg;
        zero_next    = zero_reg;
        amt_next     = amt_reg;
        code_next    = code_reg;
        char_next    = char_reg;
        last_next    = last_reg;
        stat_next    = stat_reg;
        valid_next   = valid_reg && !out_ready;
        q_pop        = 1'b0;

        unique case (state_reg)
            B_IDLE:
                if (q_valid)
                begin
                    q_pop        = 1'b1;
                    mag_next     = {43'd0, desc.mant};
                    mul_cnt_next = desc.prec;
                    neg_next     = desc.neg;
                    prec_next    = desc.prec;
                    shl_next     = desc.shl;
                    zero_next    = desc.zero;
                    amt_next     = desc.sh_amt;
                    code_next    = desc.code;
                    bit_cnt_next = 7'(MAG_W - 1);
                    for (int i = 0; i < NUM_DIGITS; i++)
                    begin
                        bcd_next[i] = 4'd0;
                    end
                end
            B_MUL:
                if (mul_cnt_reg != 4'd0)
                begin
                    mag_next     = (mag_reg << 3) + (mag_reg << 1);
                    mul_cnt_next = mul_cnt_reg - 4'd1;
                end
            B_SHIFT:
                if (shl_reg)
                begin
                    mag_next = mag_reg << amt_reg;
                end
                else if (zero_reg)
                begin
                    mag_next = '0;
                end
                else
                begin
                    // keep one guard bit for the half-up round
                    mag_next = mag_reg >> (amt_reg - 7'd1);
                end
            B_ROUND:
                mag_next = (mag_reg + MAG_W'(1)) >> 1;
            B_CONV:
            begin
                bcd_next[0] = {adj[0][2:0], mag_reg[MAG_W-1]};
                for (int i = 1; i < NUM_DIGITS; i++)
                begin
                    bcd_next[i] = {adj[i][2:0], adj[i-1][3]};
                end
                mag_next     = mag_reg << 1;
                bit_cnt_next = bit_cnt_reg - 7'd1;
                pos_next     = 5'(NUM_DIGITS - 1);
            end
            B_SCAN:
                if (pos_reg > {1'b0, prec_reg} && dig == 4'd0)
                begin
                    pos_next = pos_reg - 5'd1;
                end
            B_CHECK:
                if (too_long)
                begin
                    code_next = ST_NO_SPACE;
                end
            B_SIGN:
                if (ob_free)
                begin
                    valid_next = 1'b1;
                    char_next  = CHAR_MINUS;
                    last_next  = 1'b0;
                    stat_next  = ST_OK;
                end
            B_INT:
                if (ob_free)
                begin
                    valid_next = 1'b1;
                    char_next  = CHAR_ZERO + {4'd0, dig};
                    last_next  = (pos_reg == 5'd0);
                    stat_next  = ST_OK;
                    if (pos_reg != {1'b0, prec_reg})
                    begin
                        pos_next = pos_reg - 5'd1;
                    end
                end
            B_DOT:
                if (ob_free)
                begin
                    valid_next = 1'b1;
                    char_next  = CHAR_POINT;
                    last_next  = 1'b0;
                    stat_next  = ST_OK;
                    pos_next   = {1'b0, prec_reg} - 5'd1;
                end
            B_FRAC:
                if (ob_free)
                begin
                    valid_next = 1'b1;
                    char_next  = CHAR_ZERO + {4'd0, dig};
                    last_next  = (pos_reg == 5'd0);
                    stat_next  = ST_OK;
                    if (pos_reg != 5'd0)
                    begin
                        pos_next = pos_reg - 5'd1;
                    end
                end
            B_STAT:
                if (ob_free)
                begin
                    valid_next = 1'b1;
                    char_next  = 8'd0;
                    last_next  = 1'b1;
                    stat_next  = code_reg;
                end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg     <= mag_next;
        bcd_reg     <= bcd_next;
        mul_cnt_reg <= mul_cnt_next;
        bit_cnt_reg <= bit_cnt_next;
        pos_reg     <= pos_next;
        neg_reg     <= neg_next;
        prec_reg    <= prec_next;
        shl_reg     <= shl_next;
        zero_reg    <= zero_next;
        amt_reg     <= amt_next;
        code_reg    <= code_next;
        char_reg    <= char_next;
        last_reg    <= last_next;
        stat_reg    <= stat_next;
    end

endmodule

// ----- hw/rtl/double_to_fixed_decimal_ascii_core.sv -----
`timescale 1ns / 1ps

// Flow from input transfer to first character valid: pop, x10 scaling, binary point shift
//   and round, shift-add-3 BCD conversion of the 96-bit magnitude, leading-zero scan,
//   length check, output load; status-only items go from the pop to the output load.
// Input flow: the converter finishes one input before it takes the next and is the limit;
//   the 2-entry descriptor queue takes two more inputs while it works.
// Reset: rst_n asynchronous, active low; clears control state, precision 6, buffer_length 100.
module double_to_fixed_decimal_ascii_core (
    input  logic        clk,
    input  logic        rst_n,
    // configuration writes
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    // input channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [63:0] value_bits,
    // output channel, one transfer per character
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_char,
    output logic        last,
    output logic [1:0]  status
);
    import d2fa_pkg::*;

    logic [3:0] precision_reg;
    logic [7:0] buffer_length_reg;

    desc_t front_desc;
    desc_t head_desc;
    logic  q_full;
    logic  q_not_empty;
    logic  q_pop;
    logic  push;

    // config regs; only to be written by the user while the block is idle; the block does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            precision_reg     <= 4'd6;
            buffer_length_reg <= 8'd100;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PRECISION:  precision_reg     <= cfg_data[3:0];
                CFG_BUFFER_LEN: buffer_length_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // front: classify the double, split it into mantissa and shift
    d2fa_front u_front (
        .value_bits    (value_bits),
        .precision     (precision_reg),
        .buffer_length (buffer_length_reg),
        .desc          (front_desc)
    );

    assign in_ready = !q_full;
    assign push     = in_valid && in_ready;

    d2fa_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (front_desc),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (head_desc)
    );

    // back: scale, round, convert to BCD and stream characters
    d2fa_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_not_empty),
        .desc          (head_desc),
        .q_pop         (q_pop),
        .buffer_length (buffer_length_reg),
        .out_char      (out_char),
        .last          (last),
        .status        (status),
        .out_valid     (out_valid),
        .out_ready     (out_ready)
    );

    // a nonzero status only ever closes an item
    a_status_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> last)
        else $error("status set on a non-final transfer");

    // status-only items carry no character
    a_status_char: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> out_char == 8'd0)
        else $error("status item with a character");

    // every text character before the last is printable
    a_text_char: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> out_char != 8'd0)
        else $error("empty character inside text");

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps

// Testbench for double_to_fixed_decimal_ascii_core.
// A predictor turns each accepted binary64 word into its decimal text:
// an optional '-', the integer digits, then, for nonzero precision, '.' and the fraction digits.
// The expected characters go into a queue, and a checker compares every
// output transfer against that queue.
// Named test tasks run in turn:
//   - directed corner values
//   - a sweep over register settings
//   - random traffic under three idle mixes
//   - a long output hold-off, then a pause until the queue drains

module tb_top;

    import d2fa_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;  // cycles with no transfer at all
    localparam int TAIL_CYCLES    = 200;    // roughly one conversion latency

    typedef struct {
        logic [7:0] ch;
        logic       lst;
        status_t    st;
    } text_char_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [0:0]  cfg_index = CFG_PRECISION;
    logic [7:0]  cfg_data = 8'd0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [63:0] value_bits = 64'd0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  out_char;
    logic        last;
    logic [1:0]  status;

    // Predictor copy of the configuration registers.
    logic [3:0]  prec_reg = 4'd6;
    logic [7:0]  buflen_reg = 8'd100;

    text_char_t  text_expect[$];
    int          error_count = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_left = 0;     // receiver hold-off, counted down below
    int          quiet_cycles = 0;

    double_to_fixed_decimal_ascii_core uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .value_bits (value_bits),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_char   (out_char),
        .last       (last),
        .status     (status)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic void push_char(logic [7:0] c, logic l, status_t s);
        text_char_t t;
        t.ch  = c;
        t.lst = l;
        t.st  = s;
        text_expect.push_back(t);
    endfunction

    function automatic void predict_text(logic [63:0] v);
        logic         neg;
        logic [10:0]  ex;
        logic [52:0]  m;
        logic [127:0] mag;
        logic [127:0] rnd;
        logic [3:0]   dig[48];
        int           p, e, s, nd, len, lim, i;
        neg = v[63];
        ex  = v[62:52];
        m   = {1'b0, v[51:0]};
        p   = (prec_reg > MAX_PRECISION) ? MAX_PRECISION : prec_reg;
        // buffer check wins over everything else
        if (buflen_reg < 2) begin
            push_char(8'd0, 1'b1, ST_BUF_SMALL);
            return;
        end
        // inf, NaN and anything at or above 2^63
        if (ex == 11'h7ff || ex >= 11'd1086) begin
            push_char(8'd0, 1'b1, ST_RANGE);
            return;
        end
        if (ex != 0) begin
            m[52] = 1'b1;
            e = int'(ex) - 1075;
        end
        else
            e = -1074;
        if (m == 0)
            neg = 1'b0;     // minus zero prints without sign
        mag = {75'd0, m};
        for (i = 0; i < p; i++)
            mag = mag * 10;
        if (e >= 0)
            mag = mag << e;
        else begin
            s = -e;
            if (s >= 128)
                mag = '0;
            else begin
                // half-up on the exact binary value
                rnd = 128'd1 << (s - 1);
                mag = (mag + rnd) >> s;
            end
        end
        nd = 0;
        do begin
            dig[nd] = 4'(mag % 10);
            mag = mag / 10;
            nd++;
        end while ((mag != 0 || nd < p + 1) && nd < 48);
        len = (neg ? 1 : 0) + (nd - p) + (p > 0 ? p + 1 : 0);
        lim = int'(buflen_reg) - 1;
        if (lim > MAX_TEXT_CHARS)
            lim = MAX_TEXT_CHARS;
        if (len > lim) begin
            push_char(8'd0, 1'b1, ST_NO_SPACE);
            return;
        end
        if (neg)
            push_char(CHAR_MINUS, len == 1, ST_OK);
        for (i = nd - 1; i >= p; i--)
            push_char(CHAR_ZERO + 8'(dig[i]), (i == p) && (p == 0), ST_OK);
        if (p > 0) begin
            push_char(CHAR_POINT, 1'b0, ST_OK);
            for (i = p - 1; i >= 0; i--)
                push_char(CHAR_ZERO + 8'(dig[i]), i == 0, ST_OK);
        end
    endfunction

    // ------------------------------------------------------------------
    // Output side: ready pattern, hold-off, checker, watchdog
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Signals all change at the rising edge, so the falling edge sees
    // stable values of the transfer about to happen.
    always @(negedge clk) begin
        text_char_t t;
        if (rst_n && out_valid && out_ready) begin
            if (text_expect.size() == 0) begin
                $error("unexpected transfer: out_char=%h last=%b status=%0d",
                       out_char, last, status);
                error_count++;
            end
            else begin
                t = text_expect.pop_front();
                if (out_char !== t.ch) begin
                    $error("out_char: expected %h, got %h", t.ch, out_char);
                    error_count++;
                end
                if (last !== t.lst) begin
                    $error("last: expected %b, got %b", t.lst, last);
                    error_count++;
                end
                if (status !== t.st) begin
                    $error("status: expected %0d, got %0d", t.st, status);
                    error_count++;
                end
            end
        end
    end

    always @(negedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // Leaves in_valid high after the transfer; idle steps of the next call or
    // stop_sending lower it, so it is never dropped and raised in one step.
    task automatic send_value(input logic [63:0] v);
        logic acc;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        value_bits <= v;
        do begin
            @(negedge clk);
            acc = in_ready;
            @(posedge clk);
        end while (!acc);
        predict_text(v);
    endtask

    task automatic stop_sending();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        stop_sending();
        while (text_expect.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Register writes only with the block idle.
    task automatic write_reg(input logic [0:0] idx, input logic [7:0] data);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_PRECISION)
            prec_reg = data[3:0];
        else
            buflen_reg = data;
        @(posedge clk);
    endtask

    // Mostly numbers whose text fits, with random content; the rest noise.
    function automatic logic [63:0] random_value();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(9))
            0:       ;                                      // raw bits
            1:       v[62:52] = 11'd0;                      // zero or subnormal
            2:       v[62:52] = 11'($urandom_range(1080, 1086));
            default: v[62:52] = 11'($urandom_range(1023 - 40, 1023 + 62));
        endcase
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        logic [63:0] vals[$];
        vals = '{64'h0000000000000000, 64'h8000000000000000, 64'h3ff0000000000000,
                 64'hbff0000000000000, 64'h3fe0000000000000, 64'h4004000000000000,
                 64'h3ff8000000000000, 64'h43dfffffffffffff, 64'h43e0000000000000,
                 64'hc3e0000000000000, 64'h7ff0000000000000, 64'hfff0000000000000,
                 64'h7ff8000000000000, 64'hffffffffffffffff, 64'h0000000000000001,
                 64'h000fffffffffffff, 64'hbfd999999999999a, 64'h3fefffffffffffff};
        foreach (vals[i])
            send_value(vals[i]);
        // precision 0 rounding: 0.5 -> 1, 2.5 -> 3, -0.4 -> -0
        write_reg(CFG_PRECISION, 8'd0);
        send_value(64'h3fe0000000000000);
        send_value(64'h4004000000000000);
        send_value(64'hbfd999999999999a);
        // buffer too small, then out of space
        write_reg(CFG_BUFFER_LEN, 8'd1);
        send_value(64'h3ff0000000000000);
        write_reg(CFG_BUFFER_LEN, 8'd4);
        write_reg(CFG_PRECISION, 8'd3);
        send_value(64'h405edd2f1a9fbe77);   // 123.456 needs 7 chars
    endtask

    task automatic test_config_sweep();
        logic [7:0] blens[$];
        logic [7:0] precs[$];
        blens = '{8'd0, 8'd2, 8'd3, 8'd33, 8'd34, 8'd255, 8'd100};
        precs = '{8'd0, 8'd9, 8'd10, 8'd15, 8'd1, 8'd6};
        foreach (blens[i]) begin
            write_reg(CFG_BUFFER_LEN, blens[i]);
            write_reg(CFG_PRECISION, precs[i % precs.size()]);
            repeat (3)
                send_value(random_value());
        end
    endtask

    task automatic run_random(input int count, input int s_pct, input int r_pct);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (int i = 0; i < count; i++) begin
            if (i % 40 == 39) begin
                write_reg(CFG_PRECISION, 8'($urandom_range(15)));
                write_reg(CFG_BUFFER_LEN,
                          ($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                                   : 8'($urandom_range(20, 255)));
            end
            send_value(random_value());
        end
    endtask

    task automatic test_random();
        run_random(120, 37, 66);
        run_random(120, 66, 37);
        run_random(120, 0, 0);
    endtask

    // Receiver stalls for a long stretch while the sender keeps offering,
    // so the descriptor queue fills and in_ready drops.
    task automatic test_backpressure();
        wait_drained();
        write_reg(CFG_PRECISION, 8'd9);
        write_reg(CFG_BUFFER_LEN, 8'd255);
        send_idle_pct = 0;
        hold_left = 1500;
        repeat (6)
            send_value(random_value());
    endtask

    // Sender pauses until every expected character has arrived.
    task automatic test_drain_pause();
        send_idle_pct = 10;
        recv_idle_pct = 10;
        repeat (4)
            send_value(random_value());
        wait_drained();
        repeat (4)
            send_value(random_value());
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_config_sweep();
        test_random();
        test_backpressure();
        test_drain_pause();
        stop_sending();
        while (text_expect.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
